// File: rtl/bspline_basis_derivative_eval_defines.svh
// assertion macros for the b-spline basis evaluator
`ifndef BSPLINE_BASIS_DERIVATIVE_EVAL_DEFINES_SVH
`define BSPLINE_BASIS_DERIVATIVE_EVAL_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BSB_ASSERT_IMP(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define BSB_ASSERT_NXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/bsb_pkg.sv
// shared types, constants and codes for the b-spline basis evaluator
`timescale 1ns / 1ps
package bsb_pkg;
    localparam int MaxOrder = 16;
    localparam int StoreDepth = 2 * MaxOrder - 2;
    localparam int StoreAw = $clog2(StoreDepth);
    localparam int WorkAw = $clog2(MaxOrder);
    localparam logic [47:0] ValMax = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ValMin = 48'h8000_0000_0000;
    localparam logic [47:0] MagCap = 48'h8000_0000_0000;
    localparam logic [47:0] OneQ24 = 48'h0000_0100_0000;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_SPAN = 2'd1,
        ST_DERIV = 2'd2
    } status_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  knot_offset;
        logic [31:0] value;
        logic [3:0]  deriv_order;
    } in_word_t;

    typedef struct packed {
        logic [47:0] basis_value;
        logic [3:0]  basis_index;
        logic        last;
        logic [1:0]  status;
    } out_word_t;

    // divider handshake
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // signed 65-bit value to saturated 48 bits
    function automatic logic [47:0] sat48(input logic signed [64:0] v);
        logic [47:0] r;
        if (v > $signed({17'd0, ValMax}))
            r = ValMax;
        else if (v < $signed({{17{1'b1}}, ValMin}))
            r = ValMin;
        else
            r = v[47:0];
        return r;
    endfunction

    // magnitude plus sign to saturated 48 bits
    function automatic logic [47:0] signed_cap(input logic [63:0] m, input logic neg);
        logic [63:0] c;
        logic [47:0] r;
        c = (m > {16'd0, MagCap}) ? {16'd0, MagCap} : m;
        if (neg)
            r = 48'(~c + 64'd1);
        else if (c[47])
            r = ValMax;
        else
            r = c[47:0];
        return r;
    endfunction
endpackage

// File: rtl/bspline_basis_derivative_eval.sv
// top level: b-spline basis derivative evaluator with knot store and scratch memory
// a load word is taken and gives no result
// an evaluate word takes k*(k-1)/2 steps, each led by the two passes of the shared serial
// divider, plus the knot reads of each order step and the scratch read of each result word
// only one word is in work at a time; results wait in an output register
// rst_n clears control state and sets order_reg to 4; memories are not cleared
`timescale 1ns / 1ps
module bspline_basis_derivative_eval
    import bsb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_KR, S_KL, S_KW1, S_KW2,
        S_RDR, S_RDL, S_RDB, S_SPAN, S_DIV, S_DWAIT, S_FRAC, S_FWAIT,
        S_TERM, S_MUL1, S_MUL2, S_MUL3, S_WRB, S_WSAVE,
        S_ORD, S_OUT, S_OUTW, S_ERR
    } state_t;

    state_t      state_reg;
    logic [4:0]  order_reg;
    logic [4:0]  k_reg;
    logic [3:0]  d_reg;
    logic [31:0] x_reg;
    logic [3:0]  j_reg;
    logic [4:0]  c_reg;
    logic [47:0] saved_reg;
    logic [47:0] rd_reg;
    logic [47:0] ld_reg;
    logic [47:0] b_reg;
    logic [38:0] den_reg;
    logic [63:0] n_reg;
    logic [63:0] q1_reg;
    logic [47:0] term_reg;
    logic [63:0] p_reg;
    logic [63:0] p2_reg;
    logic [47:0] rterm_reg;
    logic [1:0]  err_reg;
    logic        out_valid_reg;
    out_word_t   out_reg;

    logic              kr_we;
    logic [StoreAw-1:0] kr_waddr;
    logic [StoreAw-1:0] kr_raddr;
    logic [31:0]       kr_rdata;
    logic              sr_we;
    logic [WorkAw+1:0] sr_waddr;
    logic [47:0]       sr_wdata;
    logic [WorkAw+1:0] sr_raddr;
    logic [47:0]       sr_rdata;
    div_ctrl_t         dctl;
    div_stat_t         dst;
    logic [63:0]       dq;
    logic [38:0]       dr;
    logic [63:0]       div_dividend;
    logic [38:0]       div_divisor;

    logic [5:0]  load_idx;
    logic        in_fire;
    logic        out_fire;
    logic [47:0] dist_val;
    logic signed [48:0] span;
    logic [4:0]  mfac;
    logic [47:0] ma;
    logic [47:0] mt;
    logic        out_free;

    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign load_idx = 6'($signed(in_data.knot_offset) + MaxOrder - 2);

    bsb_knot_ram u_knot (
        .clk(clk), .we(kr_we), .waddr(kr_waddr), .wdata(in_data.value),
        .raddr(kr_raddr), .rdata(kr_rdata)
    );

    bsb_scratch_ram u_scr (
        .clk(clk), .we(sr_we), .waddr(sr_waddr), .wdata(sr_wdata),
        .raddr(sr_raddr), .rdata(sr_rdata)
    );

    bsb_divider u_div (
        .clk(clk), .rst_n(rst_n), .ctrl(dctl), .dividend(div_dividend),
        .divisor(div_divisor), .stat(dst), .quotient(dq), .remainder(dr)
    );

    // knot store write on load, read for the two distances of step j
    assign kr_we = in_fire && (in_data.opcode == OP_LOAD) && (load_idx < 6'(StoreDepth));
    assign kr_waddr = load_idx[StoreAw-1:0];
    always_comb
    begin
        if (state_reg == S_KR)
            kr_raddr = StoreAw'(5'(j_reg) + 5'(MaxOrder - 2));
        else
            kr_raddr = StoreAw'(5'(MaxOrder - 1) - 5'(j_reg));
    end

    assign mfac = ({1'b0, j_reg} <= {1'b0, d_reg}) ? 5'd1 : 5'({1'b0, j_reg} - {1'b0, d_reg});
    assign span = $signed({rd_reg[47], rd_reg}) + $signed({ld_reg[47], ld_reg});
    assign dist_val = 48'($signed(kr_rdata)) - 48'($signed(x_reg));

    always_comb
    begin
        unique case (state_reg)
            S_KW2:   sr_raddr = '0;
            S_RDR:   sr_raddr = 6'(MaxOrder) + 6'(c_reg - 5'd1);
            S_RDL:   sr_raddr = 6'(2 * MaxOrder) + 6'(5'(j_reg) - c_reg);
            S_OUT:   sr_raddr = 6'(c_reg);
            default: sr_raddr = 6'(c_reg - 5'd1);
        endcase
    end

    always_comb
    begin
        sr_we = 1'b0;
        sr_waddr = '0;
        sr_wdata = '0;
        unique case (state_reg)
            S_KL:
            begin
                sr_we = 1'b1;
                sr_waddr = 6'(MaxOrder) + 6'(j_reg - 4'd1);
                sr_wdata = dist_val;
            end
            S_KW2:
            begin
                sr_we = 1'b1;
                sr_waddr = 6'(2 * MaxOrder) + 6'(j_reg - 4'd1);
                sr_wdata = 48'($signed(x_reg)) - 48'($signed(kr_rdata));
            end
            S_WRB:
            begin
                sr_we = 1'b1;
                sr_waddr = 6'(c_reg - 5'd1);
                if ({1'b0, j_reg} <= {1'b0, d_reg})
                    sr_wdata = sat48($signed({{17{saved_reg[47]}}, saved_reg})
                                   - $signed({{17{term_reg[47]}}, term_reg}));
                else
                    sr_wdata = sat48($signed({{17{saved_reg[47]}}, saved_reg})
                                   + $signed({{17{rterm_reg[47]}}, rterm_reg}));
            end
            S_WSAVE:
            begin
                sr_we = 1'b1;
                sr_waddr = 6'(j_reg);
                sr_wdata = saved_reg;
            end
            S_ORD:
            begin
                sr_we = 1'b1;
                sr_waddr = '0;
                sr_wdata = OneQ24;
            end
            default: ;
        endcase
    end

    assign dctl.start = (state_reg == S_DIV) || (state_reg == S_FRAC);
    assign div_dividend = (state_reg == S_DIV) ? n_reg : {9'd0, dr, 16'd0};
    assign div_divisor = den_reg;

    // shared multiplier operands: magnitudes
    assign ma = (state_reg == S_MUL1 || state_reg == S_MUL2) ? 
                (rd_reg[47] ? 48'(-rd_reg) : rd_reg) :
                (ld_reg[47] ? 48'(-ld_reg) : ld_reg);
    assign mt = term_reg[47] ? 48'(-term_reg) : term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            order_reg <= 5'd4;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                order_reg <= cfg_wdata;
            if (out_fire)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && in_data.opcode == OP_EVAL)
                    begin
                        x_reg <= in_data.value;
                        d_reg <= in_data.deriv_order;
                        if (order_reg == 5'd0)
                            k_reg <= 5'd1;
                        else if (order_reg > 5'(MaxOrder))
                            k_reg <= 5'(MaxOrder);
                        else
                            k_reg <= order_reg;
                        state_reg <= S_ORD;
                    end
                end
                S_ORD:
                begin
                    j_reg <= 4'd1;
                    c_reg <= 5'd0;
                    if ({1'b0, d_reg} >= k_reg)
                    begin
                        err_reg <= ST_DERIV;
                        state_reg <= S_ERR;
                    end
                    else if (k_reg == 5'd1)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_KR;
                end
                S_KR:  state_reg <= S_KL;
                S_KL:  state_reg <= S_KW1;
                S_KW1: state_reg <= S_KW2;
                S_KW2:
                begin
                    c_reg <= 5'd1;
                    saved_reg <= '0;
                    state_reg <= S_RDR;
                end
                S_RDR: state_reg <= S_RDL;
                S_RDL:
                begin
                    rd_reg <= sr_rdata;
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    ld_reg <= sr_rdata;
                    state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    b_reg <= sr_rdata;
                    if (span <= 0)
                    begin
                        err_reg <= ST_SPAN;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        den_reg <= 39'(span[33:0]) * 39'(mfac);
                        n_reg <= 64'((sr_rdata[47] ? 48'(-sr_rdata) : sr_rdata)) * 64'(j_reg);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:  state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (dst.done)
                    begin
                        q1_reg <= dq;
                        state_reg <= S_FRAC;
                    end
                end
                S_FRAC: state_reg <= S_FWAIT;
                S_FWAIT:
                begin
                    if (dst.done)
                    begin
                        if (q1_reg >= 64'h8000_0000)
                            term_reg <= signed_cap({16'd0, MagCap}, b_reg[47]);
                        else
                            term_reg <= signed_cap((q1_reg << 16) + dq, b_reg[47]);
                        state_reg <= S_TERM;
                    end
                end
                S_TERM:
                begin
                    if ({1'b0, j_reg} <= {1'b0, d_reg})
                        state_reg <= S_WRB;
                    else
                        state_reg <= S_MUL1;
                end
                S_MUL1, S_MUL3:
                begin
                    p_reg <= 64'(ma[32:0]) * 64'(mt[47:16]);
                    p2_reg <= 64'(ma[32:0]) * 64'(mt[15:0]);
                    state_reg <= (state_reg == S_MUL1) ? S_MUL2 : S_WRB;
                end
                S_MUL2:
                begin
                    rterm_reg <= signed_cap((p_reg >= {16'd0, MagCap}) ? {16'd0, MagCap}
                                 : p_reg + (p2_reg >> 16), rd_reg[47] != term_reg[47]);
                    state_reg <= S_MUL3;
                end
                S_WRB:
                begin
                    if ({1'b0, j_reg} <= {1'b0, d_reg})
                        saved_reg <= term_reg;
                    else
                        saved_reg <= signed_cap((p_reg >= {16'd0, MagCap}) ? {16'd0, MagCap}
                                     : p_reg + (p2_reg >> 16), ld_reg[47] != term_reg[47]);
                    if (c_reg == 5'(j_reg))
                        state_reg <= S_WSAVE;
                    else
                    begin
                        c_reg <= c_reg + 5'd1;
                        state_reg <= S_RDR;
                    end
                end
                S_WSAVE:
                begin
                    if (c_reg != 5'(j_reg))
                        state_reg <= S_WRB;
                    else if (5'(j_reg) + 5'd1 == k_reg)
                    begin
                        c_reg <= 5'd0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 4'd1;
                        state_reg <= S_KR;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_OUTW;
                end
                S_OUTW:
                begin
                    out_reg.basis_value <= sr_rdata;
                    out_reg.basis_index <= 4'(c_reg);
                    out_reg.last <= (c_reg + 5'd1 == k_reg);
                    out_reg.status <= ST_OK;
                    out_valid_reg <= 1'b1;
                    c_reg <= c_reg + 5'd1;
                    state_reg <= (c_reg + 5'd1 == k_reg) ? S_IDLE : S_OUT;
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        out_reg.basis_value <= '0;
                        out_reg.basis_index <= '0;
                        out_reg.last <= 1'b1;
                        out_reg.status <= err_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
endmodule

// File: rtl/bsb_divider.sv
// restoring divider, one quotient bit per cycle, 64-bit dividend
`timescale 1ns / 1ps
module bsb_divider
    import bsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_ctrl_t   ctrl,
    input  logic [63:0] dividend,
    input  logic [38:0] divisor,
    output div_stat_t   stat,
    output logic [63:0] quotient,
    output logic [38:0] remainder
);
    logic [63:0] q_reg;
    logic [39:0] r_reg;
    logic [38:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [39:0] shifted;
    logic [40:0] diff;

    assign shifted = {r_reg[38:0], q_reg[63]};
    assign diff = {1'b0, shifted} - {2'b00, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[40])
            begin
                r_reg <= diff[39:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg[38:0];
endmodule

// File: rtl/bsb_scratch_ram.sv
// scratch memory for distances and basis work values, registered read
`timescale 1ns / 1ps
module bsb_scratch_ram
    import bsb_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [WorkAw+1:0] waddr,
    input  logic [47:0]       wdata,
    input  logic [WorkAw+1:0] raddr,
    output logic [47:0]       rdata
);
    // rows 0..15 basis work, 16..31 right distances, 32..47 left distances
    logic [47:0] mem [0:3*MaxOrder-1];
    logic [47:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/bsb_knot_ram.sv
// knot store, one write and one registered read port
`timescale 1ns / 1ps
module bsb_knot_ram
    import bsb_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [StoreAw-1:0] waddr,
    input  logic [31:0]        wdata,
    input  logic [StoreAw-1:0] raddr,
    output logic [31:0]        rdata
);
    logic [31:0] mem [0:StoreDepth-1];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/bsb_checker.sv
// port-level checker for the b-spline basis evaluator, bound to the top level
`timescale 1ns / 1ps
`include "bspline_basis_derivative_eval_defines.svh"
module bsb_checker
    import bsb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);
    `BSB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped while stalled")
    `BSB_ASSERT_IMP(a_err_last, out_valid && out_data.status != ST_OK, out_data.last && out_data.basis_index == 4'd0 && out_data.basis_value == 48'd0, "error word malformed")
    `BSB_ASSERT_NXT(a_eval_busy, in_valid && in_ready && in_data.opcode == OP_EVAL, !in_ready, "new word taken during evaluation")
    `BSB_ASSERT_IMP(a_status_code, out_valid, out_data.status != 2'd3, "unknown status code")
endmodule

bind bspline_basis_derivative_eval bsb_checker u_bsb_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// File: tb/tb.sv
// self-checking testbench for the b-spline basis derivative evaluator
`timescale 1ns / 1ps
module tb;
    import bsb_pkg::*;

    localparam int CycleLimit = 40000000;
    localparam int DrainCycles = 20;
    localparam longint Q24Max = 64'sh7FFF_FFFF_FFFF;
    localparam longint Q24Min = -64'sh8000_0000_0000;
    localparam longint unsigned CapMag = 64'h8000_0000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [4:0] cfg_wdata = 5'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;

    in_word_t pending_words[$];
    out_word_t basis_expected[$];
    longint knot_mirror[0:StoreDepth-1];
    int order_setting = 4;
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int evals_seen = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int tx_gap = 0;
    int rx_wait = 0;
    int rx_stall = 0;
    int stall_token = 0;
    int stall_seen = 0;

    bspline_basis_derivative_eval dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint clip48(longint v);
        if (v > Q24Max)
            return Q24Max;
        if (v < Q24Min)
            return Q24Min;
        return v;
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    function automatic longint capped(longint unsigned m, bit neg);
        longint unsigned c;
        c = (m > CapMag) ? CapMag : m;
        return clip48(neg ? -longint'(c) : longint'(c));
    endfunction

    function automatic longint scaled_quotient(longint b, longint unsigned j,
                                               longint unsigned den);
        longint unsigned n, q, m;
        n = magn(b) * j;
        q = n / den;
        if (q >= (64'd1 << 31))
            m = CapMag;
        else
            m = (q << 16) + (((n % den) << 16) / den);
        return capped(m, b < 0);
    endfunction

    function automatic longint q_product(longint a, longint t);
        longint unsigned ma, mt, p, m;
        ma = magn(a);
        mt = magn(t);
        p = ma * (mt >> 16);
        if (p >= CapMag)
            m = CapMag;
        else
            m = p + ((ma * (mt & 64'hFFFF)) >> 16);
        return capped(m, (a < 0) != (t < 0));
    endfunction

    function automatic out_word_t fault_word(status_t s);
        out_word_t r;
        r = '0;
        r.last = 1'b1;
        r.status = s;
        return r;
    endfunction

    // knot store update or the expected basis words of one evaluation
    task automatic predict_basis(in_word_t w);
        longint x, saved, span, term;
        longint rd[16], ld[16], bw[16];
        longint unsigned m;
        int k, d, j, c, idx;
        out_word_t r;
        x = longint'($signed(w.value));
        if (w.opcode == OP_LOAD)
        begin
            idx = int'($signed(w.knot_offset)) + MaxOrder - 2;
            if (idx >= 0 && idx < StoreDepth)
                knot_mirror[idx] = x;
            return;
        end
        evals_seen++;
        k = order_setting < 1 ? 1 : (order_setting > MaxOrder ? MaxOrder : order_setting);
        d = int'(w.deriv_order);
        if (d >= k)
        begin
            basis_expected.push_back(fault_word(ST_DERIV));
            return;
        end
        bw[0] = 64'sd1 << 24;
        for (j = 1; j < k; j++)
        begin
            saved = 0;
            m = (j <= d) ? 64'd1 : longint'(j - d);
            rd[j-1] = knot_mirror[j + MaxOrder - 2] - x;
            ld[j-1] = x - knot_mirror[1 - j + MaxOrder - 2];
            for (c = 1; c <= j; c++)
            begin
                span = rd[c-1] + ld[j-c];
                if (span <= 0)
                begin
                    basis_expected.push_back(fault_word(ST_SPAN));
                    return;
                end
                term = scaled_quotient(bw[c-1], longint'(j), m * longint'(span));
                if (j <= d)
                begin
                    bw[c-1] = clip48(saved - term);
                    saved = term;
                end
                else
                begin
                    bw[c-1] = clip48(saved + q_product(rd[c-1], term));
                    saved = q_product(ld[j-c], term);
                end
            end
            bw[j] = saved;
        end
        for (j = 0; j < k; j++)
        begin
            r.basis_value = bw[j][47:0];
            r.basis_index = 4'(j);
            r.last = (j == k - 1);
            r.status = ST_OK;
            basis_expected.push_back(r);
        end
    endtask

    // word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    in_data <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    tx_gap <= calm ? 0 : $urandom_range(0, 13);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait <= 0;
        end
        else if (stall_token != stall_seen)
        begin
            stall_seen <= stall_token;
            rx_stall <= 700;
            out_ready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            out_ready <= (rx_stall == 1);
        end
        else if (out_valid && out_ready)
        begin
            rx_wait <= calm ? 0 : $urandom_range(0, 13);
            out_ready <= calm;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            out_ready <= (rx_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    // input prediction and result checking
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            words_in++;
            predict_basis(in_data);
        end
        if (rst_n && out_valid && out_ready)
        begin
            words_out++;
            if (basis_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
            end
            else if (basis_expected[0] !== out_data)
            begin
                errors++;
                $display("%0t: mismatch, expected val %h idx %0d last %b st %0d,",
                         $time, basis_expected[0].basis_value,
                         basis_expected[0].basis_index, basis_expected[0].last,
                         basis_expected[0].status);
                $display("    actual val %h idx %0d last %b st %0d",
                         out_data.basis_value, out_data.basis_index, out_data.last,
                         out_data.status);
                void'(basis_expected.pop_front());
            end
            else
                void'(basis_expected.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     basis_expected.size());
            $display("tb failed");
            $finish;
        end
    end

    function automatic in_word_t make_word(logic op, int off, longint val, int d);
        in_word_t w;
        w.opcode = op;
        w.knot_offset = 5'(off);
        w.value = 32'(val);
        w.deriv_order = 4'(d);
        return w;
    endfunction

    task automatic send_load(int off, longint val);
        pending_words.push_back(make_word(OP_LOAD, off, val, $urandom_range(0, 15)));
    endtask

    task automatic send_eval(longint x, int d);
        pending_words.push_back(make_word(OP_EVAL, $urandom_range(0, 31), x, d));
    endtask

    task automatic drain;
        while (pending_words.size() > 0 || in_valid || basis_expected.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_order(int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 5'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        order_setting = v;
    endtask

    // knots for one evaluation, rising unless broken, then the evaluation
    task automatic knot_set(int k, bit broken);
        longint kv[32];
        longint incmax, total, x;
        int lo, hi, o, d, bad;
        bit down;
        lo = -(k - 2);
        hi = k - 1;
        case ($urandom_range(0, 3))
            0: incmax = 8;
            1: incmax = 64'd1 << 16;
            2: incmax = 64'd1 << 20;
            default: incmax = 64'd1 << 27;
        endcase
        total = (hi > lo) ? longint'(hi - lo) * incmax : 0;
        kv[lo + 14] = longint'($urandom_range(0, 32'(64'hFFFF_FFFF - total)))
                      - 64'sd2147483648;
        bad = $urandom_range(lo + 1, hi);
        for (o = lo + 1; o <= hi; o++)
            kv[o + 14] = kv[o + 13] + ((broken && o == bad) ? 0 : $urandom_range(1, incmax));
        down = $urandom_range(0, 1);
        for (o = lo; o <= hi; o++)
            send_load(down ? hi - (o - lo) : o, kv[(down ? hi - (o - lo) : o) + 14]);
        if (k >= 2)
            x = kv[14] + longint'($urandom_range(0, 32'(kv[15] - kv[14])));
        else
            x = longint'($signed($urandom));
        d = ($urandom_range(0, 7) == 0 || k == 1) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, k - 1);
        send_eval(x, d);
    endtask

    task automatic run_phase(int n);
        int k, start;
        k = order_setting < 1 ? 1 : (order_setting > MaxOrder ? MaxOrder : order_setting);
        start = pending_words.size() + words_in;
        while (pending_words.size() + words_in - start < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: knot_set(k, 1'b0);
                6: knot_set(k, 1'b1);
                7: send_load($urandom_range(0, 31) - 16, longint'($signed($urandom)));
                8: send_eval(longint'($signed($urandom)), $urandom_range(0, 15));
                default: send_eval(longint'($signed($urandom)), $urandom_range(k, 15));
            endcase
        end
    endtask

    int orders[10] = '{1, 2, 16, 0, 31, 3, 6, 17, 5, 4};
    int phase_len[10] = '{40, 38, 28, 34, 30, 32, 34, 28, 36, 34};

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole store, offsets outside it are dropped
        for (int o = -16; o <= 15; o++)
            send_load(o, longint'($signed($urandom)));
        // extreme knots at order 4
        send_load(-2, -64'sd2147483648);
        send_load(-1, -64'sd2147483647);
        send_load(0, 0);
        send_load(1, 64'sh10000);
        send_load(2, 64'sh7FFF_FFFE);
        send_load(3, 64'sh7FFF_FFFF);
        send_eval(0, 0);
        send_eval(64'sh10000, 1);
        send_eval(64'sh8000, 3);
        send_eval(0, 4);
        send_eval(0, 15);
        // tiny spans drive high derivatives into saturation
        send_load(-2, -64'sd2147483648);
        send_load(-1, -64'sd2147483647);
        send_load(0, -64'sd2147483646);
        send_load(1, -64'sd2147483645);
        send_eval(-64'sd2147483646, 3);
        send_eval(-64'sd2147483646, 2);
        // repeated knot gives a zero span
        send_load(1, -64'sd2147483646);
        send_eval(-64'sd2147483646, 0);
        drain();

        for (int p = 0; p < 10; p++)
        begin
            write_order(orders[p]);
            calm = (p % 3 == 1);
            if (p == 1)
                stall_token++;
            if (p == 5)
            begin
                run_phase(phase_len[p] / 2);
                drain();
            end
            run_phase(phase_len[p]);
            drain();
        end

        $display("%0d words sent, %0d evaluations, %0d result words checked",
                 words_in, evals_seen, words_out);
        $display("orders 0 to 31 applied, with stalls, pauses and zero-span knots");
        if (errors == 0 && basis_expected.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
